[hw/rtl/svpd_pkg.sv]
// Package: constants, state type and sine table for the SVPWM duty generator.
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

    localparam int PHASE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic [15:0] ONE_Q15         = 16'd32768;
    localparam logic [15:0] MOD_INDEX_RESET = 16'd19661;
    localparam logic [15:0] PHASE_STEP_RESET = 16'd393;

    // Configuration register indexes
    localparam logic REG_MOD_INDEX  = 1'b0;
    localparam logic REG_PHASE_STEP = 1'b1;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] SIN60_Q30 = 64'd929887697;

    // table entries per pi radians, and the rounding offset for the sin 60 divide
    localparam logic [63:0] ANGLE_DIV      = 64'd3 * 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] SIN60_HALF_Q30 = SIN60_Q30 / 64'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SECTOR,
        S_ROM1,
        S_MUL2,
        S_MUL1,
        S_MIX
    } svpd_state_t;

    typedef logic [15:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    // sin(a)/sin(60deg) over 0..60 degrees, Q1.15, from a Taylor series in Q30
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (PI_Q30 * 64'(k)) / ANGLE_DIV;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
            term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
            term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
            term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
            val  = (sum * 64'(ONE_Q15) + SIN60_HALF_Q30) / SIN60_Q30;
            tab[k] = (val > 64'(ONE_Q15)) ? ONE_Q15 : val[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

[hw/rtl/space_vector_pwm_duty.sv]
// Top level: two-level space vector PWM duty generator with a shared multiplier.
//
// Usage:
//   Input channel (in_valid/in_ready, field advance): each request is one
//   sample tick. advance=1 adds phase_step to the phase accumulator first,
//   advance=0 recomputes at the current phase.
//   Output channel (out_valid/out_ready): one result per request, holding the
//   sector, the phase, three duties, three dwells and the overmodulation flag.
//   Config port (cfg_write/cfg_index/cfg_data): index 0 is the modulation
//   index (Q1.15, saturated at 1.0 when used), index 1 the phase step. Write
//   only while the block is idle.
// Timing:
//   An accepted request steps the sequencer through S_SECTOR, S_ROM1, S_MUL2,
//   S_MUL1 and S_MIX before out_valid rises; in_ready is high only in S_IDLE,
//   so no new request is taken until the last one leaves S_MIX. The single
//   16x16 multiplier is used three times per request (sector scaling, two
//   dwell products) and the registered sine ROM is read twice, which shapes that sequence.
// Reset: clears the phase accumulator, loads the register reset values and
//   empties the output register.
// Stall: a finished result waits in the output register; the next request
//   is accepted and worked on, and its final step holds until out_ready
//   frees the output register.
`timescale 1ns / 1ps
`default_nettype none

module space_vector_pwm_duty
    import svpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // request in
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        advance,
    // result out
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       sector,
    output logic [15:0]      phase_angle_out,
    output logic [15:0]      duty_phase_a,
    output logic [15:0]      duty_phase_b,
    output logic [15:0]      duty_phase_c,
    output logic [15:0]      dwell_first,
    output logic [15:0]      dwell_second,
    output logic [15:0]      dwell_zero,
    output logic             overmodulated
);

    svpd_state_t state_reg, state_next;

    logic [15:0]           mod_index_reg;
    logic [15:0]           phase_step_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [15:0]           p16;

    logic [18:0]           t_reg;           // 6 * phase
    logic [15:0]           d1_reg, d2_reg;
    logic [15:0]           rom_data_reg;
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic [IDX_BITS-1:0]   idx;

    logic [15:0]           mul_a, mul_b;
    logic [31:0]           mul_p;
    logic [15:0]           m_sat;

    logic                  out_valid_reg;
    logic                  out_free;
    logic                  in_accept;
    logic                  load_t, load_d2, load_d1, load_out;

    // mixing stage
    logic [16:0]           dsum;
    logic                  ov;
    logic [15:0]           dz;
    logic [14:0]           half_z;
    logic [16:0]           v_sum, v_d1, v_d2, v_h;
    logic [16:0]           da, db, dc;

    // phase step scaled to the accumulator width, phase scaled to 16 bits
    generate
        if (PHASE_BITS >= 16) begin : g_wide_phase
            assign phase_inc = PHASE_BITS'(phase_step_reg) << (PHASE_BITS - 16);
            assign p16       = phase_reg[PHASE_BITS-1 -: 16];
        end else begin : g_narrow_phase
            assign phase_inc = PHASE_BITS'(phase_step_reg >> (16 - PHASE_BITS));
            assign p16       = 16'(phase_reg) << (16 - PHASE_BITS);
        end
    endgenerate

    assign m_sat    = (mod_index_reg > ONE_Q15) ? ONE_Q15 : mod_index_reg;
    assign idx      = t_reg[15 -: IDX_BITS];
    assign mul_p    = 32'(mul_a) * 32'(mul_b);
    assign out_free = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SECTOR;
            S_SECTOR: state_next = S_ROM1;
            S_ROM1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_MUL1;
            S_MUL1:   state_next = S_MIX;
            S_MIX:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_ready = 1'b0;
        mul_a    = m_sat;
        mul_b    = rom_data_reg;
        rom_addr = ROM_ADDR_BITS'(idx);
        load_t   = 1'b0;
        load_d2  = 1'b0;
        load_d1  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_SECTOR:
            begin
                mul_a  = p16;
                mul_b  = 16'd6;
                load_t = 1'b1;
            end
            S_ROM1:   rom_addr = ROM_ADDR_BITS'(idx);
            S_MUL2:
            begin
                load_d2  = 1'b1;
                rom_addr = ROM_ADDR_BITS'(SINE_TABLE_DEPTH) - ROM_ADDR_BITS'(idx);
            end
            S_MUL1:   load_d1 = 1'b1;
            S_MIX:    load_out = out_free;
            default:  ;
        endcase
    end

    // ---------------- dwell and duty mixing ----------------
    always_comb
    begin
        dsum   = 17'(d1_reg) + 17'(d2_reg);
        ov     = dsum > 17'(ONE_Q15);
        dz     = ov ? 16'd0 : 16'(17'(ONE_Q15) - dsum);
        half_z = dz[15:1];
        v_h    = 17'(half_z);
        v_sum  = dsum + v_h;
        v_d1   = 17'(d1_reg) + v_h;
        v_d2   = 17'(d2_reg) + v_h;
        case (t_reg[18:16])
            3'd0:    begin da = v_sum; db = v_d2;  dc = v_h;   end
            3'd1:    begin da = v_d1;  db = v_sum; dc = v_h;   end
            3'd2:    begin da = v_h;   db = v_sum; dc = v_d2;  end
            3'd3:    begin da = v_h;   db = v_d1;  dc = v_sum; end
            3'd4:    begin da = v_d2;  db = v_h;   dc = v_sum; end
            default: begin da = v_sum; db = v_h;   dc = v_d1;  end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mod_index_reg  <= MOD_INDEX_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == REG_MOD_INDEX)
                    mod_index_reg <= cfg_data;
                else
                    phase_step_reg <= cfg_data;
            end
            if (in_accept && advance)
                phase_reg <= phase_reg + phase_inc;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        rom_data_reg <= SINE_TAB[rom_addr];
        if (load_t)
            t_reg <= mul_p[18:0];
        if (load_d2)
            d2_reg <= mul_p[30:15];
        if (load_d1)
            d1_reg <= mul_p[30:15];
        if (load_out)
        begin
            sector          <= t_reg[18:16];
            phase_angle_out <= p16;
            duty_phase_a    <= (da > 17'(ONE_Q15)) ? ONE_Q15 : da[15:0];
            duty_phase_b    <= (db > 17'(ONE_Q15)) ? ONE_Q15 : db[15:0];
            duty_phase_c    <= (dc > 17'(ONE_Q15)) ? ONE_Q15 : dc[15:0];
            dwell_first     <= d1_reg;
            dwell_second    <= d2_reg;
            dwell_zero      <= dz;
            overmodulated   <= ov;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------- assertions ----------------
    a_ov_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overmodulated |-> dwell_zero == 16'd0)
        else $error("overmodulated result with nonzero zero dwell");

    a_dwell_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overmodulated |->
            (17'(dwell_first) + 17'(dwell_second) + 17'(dwell_zero)) == 17'(ONE_Q15))
        else $error("dwells do not add up to one");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sector <= 3'd5)
        else $error("sector out of range");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_phase_a <= ONE_Q15 && duty_phase_b <= ONE_Q15
                      && duty_phase_c <= ONE_Q15)
        else $error("duty above one");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(phase_angle_out) && $stable(duty_phase_a))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
